@@ rtl/lcdseq_pkg.sv @@
package lcdseq_pkg;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_PUTC  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_GOTO  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_WAIT  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DELAY = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_INIT_DELAY = 2'd0;
  localparam logic [1:0] CFG_DISPLAY    = 2'd1;
  localparam logic [1:0] CFG_ENTRY      = 2'd2;

  localparam logic [7:0] INIT_DELAY_RST = 8'd30;
  localparam logic [2:0] DISPLAY_RST    = 3'd4;
  localparam logic [1:0] ENTRY_RST      = 2'd2;

  localparam int ROW_TWO_BASE_DEF = 64;
  localparam int ROW_BASE_W       = 7;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY   = 8'h08;
  localparam logic [7:0] CMD_ENTRY     = 8'h04;
  localparam logic [3:0] NIB_FUNC_4BIT = 4'h2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int STEP_IDX_W = 5;

  typedef struct packed {
    op_t        op;
    logic       rs;
    logic [7:0] cmd;
  } req_t;

  typedef struct packed {
    kind_t      kind;
    logic       rs;
    logic [3:0] nibble;
    logic [7:0] delay_ms;
    logic       last;
  } step_t;

  typedef struct packed {
    logic [7:0] init_delay_ms;
    logic [2:0] display_flags;
    logic [1:0] entry_mode_flags;
  } cfg_t;

  function automatic step_t wait_step(input logic last);
    step_t s;
    s.kind     = KIND_WAIT;
    s.rs       = 1'b0;
    s.nibble   = 4'h0;
    s.delay_ms = 8'h00;
    s.last     = last;
    return s;
  endfunction

  function automatic step_t write_step(input logic rs, input logic [3:0] nib,
                                       input logic last);
    step_t s;
    s.kind     = KIND_WRITE;
    s.rs       = rs;
    s.nibble   = nib;
    s.delay_ms = 8'h00;
    s.last     = last;
    return s;
  endfunction

  function automatic step_t delay_step(input logic [7:0] ms);
    step_t s;
    s.kind     = KIND_DELAY;
    s.rs       = 1'b0;
    s.nibble   = 4'h0;
    s.delay_ms = ms;
    s.last     = 1'b0;
    return s;
  endfunction

  // power-up run: function-set nibbles, full function set, then setup commands
  function automatic step_t init_step(input logic [STEP_IDX_W-1:0] idx, input cfg_t cfg);
    logic [7:0] disp;
    logic [7:0] entry;
    step_t      s;
    disp  = CMD_DISPLAY | {5'b0, cfg.display_flags};
    entry = CMD_ENTRY | {6'b0, cfg.entry_mode_flags};
    case (idx)
      5'd0, 5'd2, 5'd4:         s = write_step(1'b0, NIB_FUNC_4BIT, 1'b0);
      5'd6, 5'd9:               s = write_step(1'b0, CMD_FUNC_SET[7:4], 1'b0);
      5'd7, 5'd10:              s = write_step(1'b0, CMD_FUNC_SET[3:0], 1'b0);
      5'd1, 5'd3, 5'd5, 5'd8, 5'd11: s = delay_step(cfg.init_delay_ms);
      5'd12, 5'd15, 5'd18, 5'd21: s = wait_step(1'b0);
      5'd13:                    s = write_step(1'b0, disp[7:4], 1'b0);
      5'd14:                    s = write_step(1'b0, disp[3:0], 1'b0);
      5'd16:                    s = write_step(1'b0, CMD_CLEAR[7:4], 1'b0);
      5'd17:                    s = write_step(1'b0, CMD_CLEAR[3:0], 1'b0);
      5'd19:                    s = write_step(1'b0, entry[7:4], 1'b0);
      5'd20:                    s = write_step(1'b0, entry[3:0], 1'b0);
      5'd22:                    s = write_step(1'b0, CMD_SET_DDRAM[7:4], 1'b0);
      5'd23:                    s = write_step(1'b0, CMD_SET_DDRAM[3:0], 1'b0);
      default:                  s = wait_step(1'b1);
    endcase
    return s;
  endfunction

  // wait, high nibble, low nibble, and a trailing wait for go to position
  function automatic step_t cmd_step(input req_t req, input logic [STEP_IDX_W-1:0] idx);
    step_t s;
    case (idx)
      5'd0:    s = wait_step(1'b0);
      5'd1:    s = write_step(req.rs, req.cmd[7:4], 1'b0);
      5'd2:    s = write_step(req.rs, req.cmd[3:0], req.op != OP_GOTO);
      default: s = wait_step(1'b1);
    endcase
    return s;
  endfunction

endpackage

@@ rtl/lcdseq_front.sv @@
module lcdseq_front #(
  parameter int ROW_TWO_BASE = lcdseq_pkg::ROW_TWO_BASE_DEF
) (
  input  lcdseq_pkg::op_t  op,
  input  logic [7:0]       char_code,
  input  logic [3:0]       column,
  input  logic             row,
  output lcdseq_pkg::req_t req
);
  import lcdseq_pkg::*;

  localparam logic [ROW_BASE_W-1:0] RowBase = ROW_BASE_W'(ROW_TWO_BASE);

  logic [7:0] goto_cmd;

  assign goto_cmd = CMD_SET_DDRAM | {1'b0, (row ? RowBase : {ROW_BASE_W{1'b0}})}
                  | {4'b0, column};

  always_comb begin
    req.op = op;
    case (op)
      OP_PUTC: begin
        req.rs  = 1'b1;
        req.cmd = char_code;
      end
      OP_CLEAR: begin
        req.rs  = 1'b0;
        req.cmd = CMD_CLEAR;
      end
      OP_GOTO: begin
        req.rs  = 1'b0;
        req.cmd = goto_cmd;
      end
      default: begin
        req.rs  = 1'b0;
        req.cmd = 8'h00;
      end
    endcase
  end

endmodule

@@ rtl/lcdseq_queue.sv @@
module lcdseq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcdseq_pkg::req_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output lcdseq_pkg::req_t head
);
  import lcdseq_pkg::*;

  req_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/lcdseq_back.sv @@
module lcdseq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lcdseq_pkg::cfg_t  cfg,
  input  logic              empty,
  input  lcdseq_pkg::req_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output lcdseq_pkg::step_t out_step
);
  import lcdseq_pkg::*;

  logic [STEP_IDX_W-1:0] idx_r, idx_nxt;
  logic                  valid_r, valid_nxt;
  step_t                 step_r;
  step_t                 step_cur;
  logic                  adv;

  assign adv      = !empty && (!valid_r || out_ready);
  assign step_cur = (head.op == OP_INIT) ? init_step(idx_r, cfg) : cmd_step(head, idx_r);
  assign pop      = adv && step_cur.last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = 1'b1;
      idx_nxt   = step_cur.last ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step_r <= step_cur;
    end
  end

  assign out_valid = valid_r;
  assign out_step  = step_r;

endmodule

@@ rtl/char_lcd_nibble_bus_sequencer_top.sv @@
// when the back end is idle, the first bus step of a request passes through the queue slot
//   and then the registered output stage before it shows on out_tvalid
// throughput: one bus step per cycle while out_tready is high; a request issues
//   3 (put character, clear), 4 (go to position) or 25 (initialize) bus steps
// a two-entry request queue lets new requests in while steps are still going out
// reset: synchronous rst_n empties the queue and output stage, config back to 30/4/2
module char_lcd_nibble_bus_sequencer_top #(
  parameter int ROW_TWO_BASE = lcdseq_pkg::ROW_TWO_BASE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // char_code[7:0], column[11:8], row[12]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // nibble[3:0], delay_ms[11:4]
  output logic [2:0]  out_tuser,  // step_kind[1:0], register_select[2]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lcdseq_pkg::*;

  cfg_t  cfg_r;
  req_t  front_req;
  req_t  head;
  logic  q_full, q_empty, q_pop;
  step_t step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_delay_ms    <= INIT_DELAY_RST;
      cfg_r.display_flags    <= DISPLAY_RST;
      cfg_r.entry_mode_flags <= ENTRY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INIT_DELAY: cfg_r.init_delay_ms    <= cfg_data;
        CFG_DISPLAY:    cfg_r.display_flags    <= cfg_data[2:0];
        CFG_ENTRY:      cfg_r.entry_mode_flags <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  lcdseq_front #(
    .ROW_TWO_BASE(ROW_TWO_BASE)
  ) u_front (
    .op        (op_t'(in_tuser)),
    .char_code (in_tdata[7:0]),
    .column    (in_tdata[11:8]),
    .row       (in_tdata[12]),
    .req       (front_req)
  );

  assign in_tready = !q_full;

  lcdseq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (front_req),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  lcdseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .empty     (q_empty),
    .head      (head),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_step  (step)
  );

  assign out_tdata = {4'b0, step.delay_ms, step.nibble};
  assign out_tuser = {step.rs, step.kind};
  assign out_tlast = step.last;

endmodule
